// ----- design/page_bump_allocator_top_assert.svh -----
// Assertion macros for the page bump allocator.
`ifndef PAGE_BUMP_ALLOCATOR_TOP_ASSERT_SVH
`define PAGE_BUMP_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked property, held off while reset is applied.
`define PBA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("page bump allocator check failed");
// Checked property, also evaluated during reset.
`define PBA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("page bump allocator check failed");
`else
`define PBA_ASSERT(label, clk, rst_n, prop)
`define PBA_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- design/pba_pkg.sv -----
// Package: types and constants shared by the page bump allocator.
package pba_pkg;

    localparam int ADDR_W     = 48;
    localparam int COUNT_W    = 36;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;

    localparam logic [ADDR_W-1:0] PAGE_MASK      = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [ADDR_W-1:0] RESERVED_FLOOR = ADDR_W'(64'h20_0000);
    localparam logic [ADDR_W-1:0] WINDOW_LOW     = ADDR_W'(64'h9_EFFF);
    localparam logic [ADDR_W-1:0] LIMIT_RESET    = ADDR_W'(64'h2000_0000);
    localparam logic [ADDR_W-1:0] BUMP_RESET     = ADDR_W'(64'h400_0000);
    localparam logic [ADDR_W-1:0] VERSION_RESET  = ADDR_W'(64'd1);

    // request modes; code 3 behaves as "any pages"
    localparam logic [1:0] ACT_BELOW = 2'd1;
    localparam logic [1:0] ACT_FIXED = 2'd2;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_INVALID      = 2'd1,
        ST_NO_RESOURCES = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         action;
        logic [COUNT_W-1:0] page_count;
        logic [ADDR_W-1:0]  address;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] granted_address;
        logic [ADDR_W-1:0] map_version;
    } t_rsp;

    // classified request handed from front to back
    typedef struct packed {
        logic              bump;       // needs the bump pointer
        logic              pre_fail;   // already decided as a failure
        t_status           pre_status;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] cand;       // candidate base for below/fixed modes
        logic              size_fits;  // size <= region limit
        logic [ADDR_W-1:0] room;       // region limit - size
    } t_cls;

endpackage

// ----- design/page_bump_allocator_top.sv -----
// Top level of the page bump allocator: region limit register, front and back ends.
//
// Page allocator built around a bump pointer. Each request gives a mode
// (any pages, below a maximum address, at a fixed address), a page count in
// 4 KiB pages and an address; each produces exactly one result item with a
// status (0 success, 1 invalid parameter, 2 out of resources), the granted
// start address (0 on failure) and the success counter after the request.
// Any-pages requests round the pointer up to a page, check the region limit
// and advance the pointer; below-maximum requests place the pages just under
// the given address, raised to the 2 MiB reserved floor; fixed requests are
// refused when unaligned, inside the low firmware window or past the limit.
// Both sides behave as queues: push an item while full is low, take results
// while empty is low by raising pop. Sustained rate is one item per clock
// while pop keeps the result queue from filling; an item passes the front
// queue and then the result queue before it is visible. The front end does
// all checks that do not need the bump pointer and fills a two-entry queue;
// the back end does the pointer rounding, final limit compare and counter
// update, which is the loop that sets the rate, and drains into a two-entry
// result queue. Write region_limit (reset 0x2000_0000) only while the block
// is idle. After reset the pointer is 0x400_0000, the success counter is 1.
module page_bump_allocator_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pba_pkg::ADDR_W-1:0] i_cfg_wdata,
    input  logic                       push,
    output logic                       full,
    input  pba_pkg::t_req              i_req,
    output logic                       empty,
    input  logic                       pop,
    output pba_pkg::t_rsp              o_rsp
);

    logic [pba_pkg::ADDR_W-1:0] r_limit;
    logic [pba_pkg::ADDR_W-1:0] n_limit;
    logic                       cls_valid;
    logic                       cls_pop;
    pba_pkg::t_cls              cls;

    always_comb begin
        n_limit = i_cfg_we ? i_cfg_wdata : r_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= pba_pkg::LIMIT_RESET;
        end else begin
            r_limit <= n_limit;
        end
    end

    // classify and queue
    pba_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req       (i_req),
        .i_limit     (r_limit),
        .o_cls_valid (cls_valid),
        .o_cls       (cls),
        .i_cls_pop   (cls_pop)
    );

    // bump pointer, counter, results
    pba_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (cls_valid),
        .i_cls       (cls),
        .o_cls_pop   (cls_pop),
        .empty       (empty),
        .pop         (pop),
        .o_rsp       (o_rsp)
    );

endmodule

// ----- design/pba_front.sv -----
// Front end: accepts requests, classifies them and queues them for the back end.
`include "page_bump_allocator_top_assert.svh"

module pba_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  pba_pkg::t_req              i_req,
    input  logic [pba_pkg::ADDR_W-1:0] i_limit,
    output logic                       o_cls_valid,
    output pba_pkg::t_cls              o_cls,
    input  logic                       i_cls_pop
);

    pba_pkg::t_cls              n_cls;
    pba_pkg::t_cls              r_mem [2];
    logic                       r_wp;
    logic                       r_rp;
    logic [1:0]                 r_cnt;
    logic [pba_pkg::ADDR_W-1:0] size;
    logic [pba_pkg::ADDR_W-1:0] below_diff;
    logic [pba_pkg::ADDR_W-1:0] below_base;
    logic                       wr;
    logic                       rd;

    assign full        = (r_cnt == 2'd2);
    assign o_cls_valid = (r_cnt != 2'd0);
    assign o_cls       = r_mem[r_rp];
    assign wr          = push && !full;
    assign rd          = i_cls_pop && o_cls_valid;

    always_comb begin
        size       = pba_pkg::ADDR_W'(i_req.page_count) << pba_pkg::PAGE_SHIFT;
        below_diff = i_req.address - size;
        below_base = below_diff & ~pba_pkg::PAGE_MASK;
        if (below_base < pba_pkg::RESERVED_FLOOR) begin
            below_base = pba_pkg::RESERVED_FLOOR;
        end

        n_cls            = '0;
        n_cls.size       = size;
        n_cls.size_fits  = (size <= i_limit);
        n_cls.room       = i_limit - size;
        n_cls.pre_status = pba_pkg::ST_OK;
        case (i_req.action)
            pba_pkg::ACT_FIXED: begin
                n_cls.cand = i_req.address;
                if ((i_req.address & pba_pkg::PAGE_MASK) != '0) begin
                    n_cls.pre_fail   = 1'b1;
                    n_cls.pre_status = pba_pkg::ST_INVALID;
                end else if (i_req.address < pba_pkg::RESERVED_FLOOR &&
                             i_req.address >= pba_pkg::WINDOW_LOW) begin
                    // low firmware window
                    n_cls.pre_fail   = 1'b1;
                    n_cls.pre_status = pba_pkg::ST_NO_RESOURCES;
                end
            end
            pba_pkg::ACT_BELOW: begin
                n_cls.cand = below_base;
                if (i_req.address < size) begin
                    n_cls.pre_fail   = 1'b1;
                    n_cls.pre_status = pba_pkg::ST_NO_RESOURCES;
                end
            end
            default: begin
                n_cls.bump = 1'b1;
            end
        endcase
        // zero count overrides every mode
        if (i_req.page_count == '0) begin
            n_cls.pre_fail   = 1'b1;
            n_cls.pre_status = pba_pkg::ST_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= n_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `PBA_ASSERT(a_front_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3)
    `PBA_ASSERT(a_front_fill, i_clk, i_rst_n, wr && !rd |=> r_cnt == $past(r_cnt) + 2'd1)
    `PBA_ASSERT(a_front_ptrs, i_clk, i_rst_n, (r_cnt == 2'd1) |-> (r_wp != r_rp))

endmodule

// ----- design/pba_back.sv -----
// Back end: bump pointer, success counter and the result queue.
`include "page_bump_allocator_top_assert.svh"

module pba_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cls_valid,
    input  pba_pkg::t_cls i_cls,
    output logic          o_cls_pop,
    output logic          empty,
    input  logic          pop,
    output pba_pkg::t_rsp o_rsp
);

    logic [pba_pkg::ADDR_W-1:0]     r_next_free;
    logic [pba_pkg::ADDR_W-1:0]     r_alloc_count;
    pba_pkg::t_rsp                  r_mem [2];
    logic                           r_wp;
    logic                           r_rp;
    logic [1:0]                     r_cnt;
    pba_pkg::t_rsp                  n_rsp;
    logic [pba_pkg::ADDR_W-1:0]     n_next_free;
    logic [pba_pkg::ADDR_W-1:0]     n_alloc_count;
    logic [pba_pkg::ADDR_W-1:0]     base;
    logic [pba_pkg::PAGE_NUM_W-1:0] page_hi;
    logic                           page_part;
    logic                           wrap;
    logic                           ok;
    logic                           take;
    logic                           rd;

    assign take      = i_cls_valid && (r_cnt != 2'd2);
    assign o_cls_pop = take;
    assign empty     = (r_cnt == 2'd0);
    assign o_rsp     = r_mem[r_rp];
    assign rd        = pop && !empty;

    always_comb begin
        page_hi   = r_next_free[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT];
        page_part = |r_next_free[pba_pkg::PAGE_SHIFT-1:0];
        // rounding up would leave the address space
        wrap      = (&page_hi) && page_part;
        base      = i_cls.cand;
        if (i_cls.bump) begin
            base = {page_hi + pba_pkg::PAGE_NUM_W'(page_part),
                    pba_pkg::PAGE_SHIFT'(0)};
        end
        ok = !i_cls.pre_fail && !(i_cls.bump && wrap) &&
             i_cls.size_fits && (base <= i_cls.room);

        n_next_free   = r_next_free;
        n_alloc_count = r_alloc_count;
        n_rsp         = '0;
        if (ok) begin
            n_alloc_count         = r_alloc_count + pba_pkg::ADDR_W'(1);
            n_rsp.status          = pba_pkg::ST_OK;
            n_rsp.granted_address = base;
            if (i_cls.bump) begin
                n_next_free = base + i_cls.size;
            end
        end else if (i_cls.pre_fail) begin
            n_rsp.status = i_cls.pre_status;
        end else begin
            n_rsp.status = pba_pkg::ST_NO_RESOURCES;
        end
        n_rsp.map_version = n_alloc_count;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mem[r_wp] <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free   <= pba_pkg::BUMP_RESET;
            r_alloc_count <= pba_pkg::VERSION_RESET;
            r_wp          <= 1'b0;
            r_rp          <= 1'b0;
            r_cnt         <= 2'd0;
        end else begin
            if (take) begin
                r_next_free   <= n_next_free;
                r_alloc_count <= n_alloc_count;
                r_wp          <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            case ({take, rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `PBA_ASSERT(a_back_fail_holds, i_clk, i_rst_n, take && !ok |=> $stable(r_alloc_count) && $stable(r_next_free))
    `PBA_ASSERT(a_back_grant_aligned, i_clk, i_rst_n, take && ok |-> (base & pba_pkg::PAGE_MASK) == '0)
    `PBA_ASSERT(a_back_bump_only, i_clk, i_rst_n, take && !i_cls.bump |=> $stable(r_next_free))

endmodule
